// ----- hdl/length_framed_packet_receiver_macros.svh -----
// Assertion macros shared by the length-framed packet receiver modules.
`ifndef LENGTH_FRAMED_PACKET_RECEIVER_MACROS_SVH
`define LENGTH_FRAMED_PACKET_RECEIVER_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low
`define LFPR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low
`define LFPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/lfpr_pkg.sv -----
// Types and constants shared by the length-framed packet receiver modules.
package lfpr_pkg;

    // Receiver phase
    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_SECOND = 2'd1,
        PH_FRAME  = 2'd2
    } phase_t;

    // Result status codes
    localparam logic [2:0] ST_ONGOING  = 3'd0;
    localparam logic [2:0] ST_COMPLETE = 3'd1;
    localparam logic [2:0] ST_OVERRUN  = 3'd2;
    localparam logic [2:0] ST_BAD_STOP = 3'd3;
    localparam logic [2:0] ST_TIMEOUT  = 3'd4;

    // Input kind carried on s_tuser
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] CFG_FIRST_START  = 3'd0;
    localparam logic [2:0] CFG_SECOND_START = 3'd1;
    localparam logic [2:0] CFG_STOP         = 3'd2;
    localparam logic [2:0] CFG_LENGTH_OFF   = 3'd3;
    localparam logic [2:0] CFG_BODY_OFF     = 3'd4;
    localparam logic [2:0] CFG_MAX_FRAME    = 3'd5;
    localparam logic [2:0] CFG_TIMEOUT      = 3'd6;
    localparam logic [2:0] CFG_BIG_ENDIAN   = 3'd7;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Result field widths and output packing
    typedef logic [9:0] index_t;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_PAD_W   = 3;

    typedef struct packed {
        logic [7:0]  first_start_byte;
        logic [7:0]  second_start_byte;
        logic [7:0]  stop_byte;
        logic [9:0]  length_offset;
        logic [9:0]  body_offset;
        logic [9:0]  max_frame_bytes;
        logic [15:0] timeout_ticks;
        logic        length_big_endian;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        first_start_byte:  8'd18,
        second_start_byte: 8'd52,
        stop_byte:         8'd10,
        length_offset:     10'd2,
        body_offset:       10'd4,
        max_frame_bytes:   10'd128,
        timeout_ticks:     16'd100,
        length_big_endian: 1'b0
    };

    // Classified beat passed from front to back
    typedef struct packed {
        logic       is_tick;
        logic [7:0] rx_byte;
        logic       first_hit;
        logic       second_hit;
        logic       stop_hit;
    } item_t;

endpackage

// ----- hdl/length_framed_packet_receiver.sv -----
// Top level of the length-framed packet receiver: configuration registers and wiring.
//
// Takes one beat per clock cycle while the queue has room: each beat is classified on
// entry and queued in a two-entry queue, and the framing engine retires one queued beat
// per cycle. With the queue empty, a beat that yields a result passes the queue and the
// output register before it shows on m_tvalid; start bytes, ticks but a frame timeout and
// bytes outside a frame yield none. The engine retires a beat only while the output
// register is free or draining, so with m_tready low the queue fills and s_tready drops:
// in steady flow one more beat is taken after the output stalls, from an empty queue two.
// COUNT_BITS sets the frame byte counter; byte_index carries its low ten bits.
module length_framed_packet_receiver
#(
    parameter int COUNT_BITS  = 10,
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,    // [7:0] rx_byte
    input  logic [0:0]                          s_tuser,    // [0] action
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lfpr_pkg::OUT_TDATA_W-1:0]    m_tdata,    // [7:0] frame_byte,
                                                            // [17:8] byte_index,
                                                            // [20:18] status
    output logic                                m_tlast,    // last
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lfpr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lfpr_pkg::CFG_DATA_W-1:0]     cfg_data
);

    lfpr_pkg::cfg_t     cfg_reg, cfg_next;
    lfpr_pkg::item_t    push_item, head_item;
    logic               push, q_full, pop, head_valid;

    assign cfg_ready = 1'b1;

    // Configuration register write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                lfpr_pkg::CFG_FIRST_START:  cfg_next.first_start_byte  = cfg_data[7:0];
                lfpr_pkg::CFG_SECOND_START: cfg_next.second_start_byte = cfg_data[7:0];
                lfpr_pkg::CFG_STOP:         cfg_next.stop_byte         = cfg_data[7:0];
                lfpr_pkg::CFG_LENGTH_OFF:   cfg_next.length_offset     = cfg_data[9:0];
                lfpr_pkg::CFG_BODY_OFF:     cfg_next.body_offset       = cfg_data[9:0];
                lfpr_pkg::CFG_MAX_FRAME:    cfg_next.max_frame_bytes   = cfg_data[9:0];
                lfpr_pkg::CFG_TIMEOUT:      cfg_next.timeout_ticks     = cfg_data[15:0];
                lfpr_pkg::CFG_BIG_ENDIAN:   cfg_next.length_big_endian = cfg_data[0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= lfpr_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: accept and classify
    lfpr_front u_front
    (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cfg        (cfg_reg),
        .q_full     (q_full),
        .push       (push),
        .push_item  (push_item)
    );

    // Beat queue
    lfpr_queue #(
        .DEPTH      (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // Back end: framing engine
    lfpr_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

// ----- hdl/lfpr_front.sv -----
// Front end: takes input beats, classifies them against the marker bytes.
module lfpr_front
(
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,    // [7:0] rx_byte
    input  logic [0:0]          s_tuser,    // [0] action
    input  lfpr_pkg::cfg_t      cfg,
    input  logic                q_full,
    output logic                push,
    output lfpr_pkg::item_t     push_item
);

    // Accept whenever the queue has room
    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    // Marker compares do not depend on receiver state
    always_comb
    begin
        push_item.is_tick    = (s_tuser[0] == lfpr_pkg::ACT_TICK);
        push_item.rx_byte    = s_tdata;
        push_item.first_hit  = (s_tdata == cfg.first_start_byte);
        push_item.second_hit = (s_tdata == cfg.second_start_byte);
        push_item.stop_hit   = (s_tdata == cfg.stop_byte);
    end

endmodule

// ----- hdl/lfpr_queue.sv -----
// Short queue of classified beats between the front and back ends.
`include "length_framed_packet_receiver_macros.svh"

module lfpr_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  lfpr_pkg::item_t     push_item,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output lfpr_pkg::item_t     head_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lfpr_pkg::item_t  mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full       = (cnt_reg == CNT_W'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    `LFPR_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_reg <= CNT_W'(DEPTH), "queue count above depth")
    `LFPR_ASSERT_NEXT(a_push_grows, push && !pop, cnt_reg == $past(cnt_reg) + 1'b1, "push lost")

endmodule

// ----- hdl/lfpr_back.sv -----
// Back end: framing engine and output register.
`include "length_framed_packet_receiver_macros.svh"

module lfpr_back
#(
    parameter int COUNT_BITS = 10
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  lfpr_pkg::cfg_t                      cfg,
    input  logic                                head_valid,
    input  lfpr_pkg::item_t                     head_item,
    output logic                                pop,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lfpr_pkg::OUT_TDATA_W-1:0]    m_tdata,    // [7:0] frame_byte,
                                                            // [17:8] byte_index,
                                                            // [20:18] status
    output logic                                m_tlast     // last
);

    // Compare width covers count + 1 and body_offset + frame_length
    localparam int CMP_W = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 2;

    lfpr_pkg::phase_t       phase_reg, phase_next;
    logic [COUNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [15:0]            elapsed_reg, elapsed_next;
    logic [7:0]             lfb_reg, lfb_next;
    logic [7:0]             lsb_reg, lsb_next;
    logic [15:0]            flen_reg, flen_next;

    logic                   out_valid_reg;
    logic [7:0]             out_byte_reg;
    lfpr_pkg::index_t       out_index_reg;
    logic [2:0]             out_status_reg;
    logic                   out_last_reg;

    // Per-beat decisions
    logic [CMP_W-1:0]       idx_w, n_w, body_w, max_w, loff_w;
    logic                   hit_a, hit_b, cnt_full, over, at_body, past_body;
    logic                   too_big, at_end, timed_out, in_frame_byte;
    logic [15:0]            len_formed;
    logic                   res_fire, res_last;
    logic [2:0]             res_status;
    logic [7:0]             res_byte;

    // Take a beat when the output register is free or draining
    assign pop = head_valid && (!out_valid_reg || m_tready);

    // Frame byte arithmetic
    always_comb
    begin
        idx_w      = CMP_W'(cnt_reg);
        n_w        = idx_w + 1'b1;
        body_w     = CMP_W'(cfg.body_offset);
        max_w      = CMP_W'(cfg.max_frame_bytes);
        loff_w     = CMP_W'(cfg.length_offset);
        hit_a      = (idx_w == loff_w);
        hit_b      = (idx_w == loff_w + 1'b1);
        lfb_next   = hit_a ? head_item.rx_byte : lfb_reg;
        lsb_next   = (!hit_a && hit_b) ? head_item.rx_byte : lsb_reg;
        len_formed = cfg.length_big_endian ? {lfb_next, lsb_next} : {lsb_next, lfb_next};
        cnt_full   = &cnt_reg;
        over       = cnt_full || (n_w >= max_w);
        at_body    = (n_w == body_w);
        past_body  = (n_w > body_w);
        too_big    = (CMP_W'(flen_reg) >= max_w);
        at_end     = (n_w > body_w + CMP_W'(flen_reg));
        timed_out  = (elapsed_reg >= cfg.timeout_ticks);
        in_frame_byte = (phase_reg == lfpr_pkg::PH_FRAME) && !head_item.is_tick;
    end

    // Result selection
    always_comb
    begin
        res_fire   = 1'b0;
        res_last   = 1'b0;
        res_status = lfpr_pkg::ST_ONGOING;
        res_byte   = head_item.rx_byte;
        if (phase_reg == lfpr_pkg::PH_FRAME)
        begin
            if (head_item.is_tick)
            begin
                if (timed_out)
                begin
                    res_fire   = 1'b1;
                    res_last   = 1'b1;
                    res_status = lfpr_pkg::ST_TIMEOUT;
                    res_byte   = '0;
                end
            end
            else
            begin
                res_fire = 1'b1;
                priority if (over)
                begin
                    res_last   = 1'b1;
                    res_status = lfpr_pkg::ST_OVERRUN;
                end
                else if (at_body)
                begin
                    res_status = lfpr_pkg::ST_ONGOING;
                end
                else if (past_body && too_big)
                begin
                    res_last   = 1'b1;
                    res_status = lfpr_pkg::ST_OVERRUN;
                end
                else if (past_body && at_end)
                begin
                    res_last   = 1'b1;
                    res_status = head_item.stop_hit ? lfpr_pkg::ST_COMPLETE
                                                    : lfpr_pkg::ST_BAD_STOP;
                end
                else
                begin
                    res_status = lfpr_pkg::ST_ONGOING;
                end
            end
        end
    end

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (pop)
        begin
            unique case (phase_reg)
                lfpr_pkg::PH_HUNT:
                begin
                    if (!head_item.is_tick && head_item.first_hit)
                    begin
                        phase_next = lfpr_pkg::PH_SECOND;
                    end
                end
                lfpr_pkg::PH_SECOND:
                begin
                    if (head_item.is_tick)
                    begin
                        if (timed_out)
                        begin
                            phase_next = lfpr_pkg::PH_HUNT;
                        end
                    end
                    else
                    begin
                        phase_next = head_item.second_hit ? lfpr_pkg::PH_FRAME
                                                          : lfpr_pkg::PH_HUNT;
                    end
                end
                lfpr_pkg::PH_FRAME:
                begin
                    if (res_last)
                    begin
                        phase_next = lfpr_pkg::PH_HUNT;
                    end
                end
                default:
                begin
                    phase_next = lfpr_pkg::PH_HUNT;
                end
            endcase
        end
    end

    // Counters and length bytes
    always_comb
    begin
        cnt_next     = cnt_reg;
        elapsed_next = elapsed_reg;
        flen_next    = flen_reg;
        if (pop)
        begin
            if (head_item.is_tick)
            begin
                if (phase_reg != lfpr_pkg::PH_HUNT && !timed_out)
                begin
                    elapsed_next = elapsed_reg + 1'b1;
                end
            end
            else
            begin
                unique case (phase_reg)
                    lfpr_pkg::PH_HUNT:
                    begin
                        if (head_item.first_hit)
                        begin
                            elapsed_next = '0;
                        end
                    end
                    lfpr_pkg::PH_SECOND:
                    begin
                        if (head_item.second_hit)
                        begin
                            cnt_next     = COUNT_BITS'(2);
                            elapsed_next = '0;
                            flen_next    = '0;
                        end
                    end
                    lfpr_pkg::PH_FRAME:
                    begin
                        if (!over)
                        begin
                            cnt_next = cnt_reg + 1'b1;
                            if (at_body)
                            begin
                                flen_next = len_formed;
                            end
                        end
                    end
                    default:
                    begin
                        cnt_next = cnt_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= lfpr_pkg::PH_HUNT;
            cnt_reg       <= '0;
            elapsed_reg   <= '0;
            lfb_reg       <= '0;
            lsb_reg       <= '0;
            flen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            elapsed_reg <= elapsed_next;
            flen_reg    <= flen_next;
            // Length bytes cleared at frame start, captured inside the frame
            if (pop && !head_item.is_tick && phase_reg == lfpr_pkg::PH_SECOND
                && head_item.second_hit)
            begin
                lfb_reg <= '0;
                lsb_reg <= '0;
            end
            else if (pop && in_frame_byte)
            begin
                lfb_reg <= lfb_next;
                lsb_reg <= lsb_next;
            end
            // Output register valid
            if (pop)
            begin
                out_valid_reg <= res_fire;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload, no reset
    always_ff @(posedge clk)
    begin
        if (pop && res_fire)
        begin
            out_byte_reg   <= res_byte;
            out_index_reg  <= lfpr_pkg::index_t'(cnt_reg);
            out_status_reg <= res_status;
            out_last_reg   <= res_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{lfpr_pkg::OUT_PAD_W{1'b0}}, out_status_reg, out_index_reg, out_byte_reg};
    assign m_tlast  = out_last_reg;

    `LFPR_ASSERT_NEXT(a_last_to_hunt, pop && res_fire && res_last,
        phase_reg == lfpr_pkg::PH_HUNT, "frame not closed after last result")
    `LFPR_ASSERT_IMPL(a_status_last, out_valid_reg,
        out_last_reg == (out_status_reg != lfpr_pkg::ST_ONGOING), "status and last disagree")
    `LFPR_ASSERT_IMPL(a_count_floor, phase_reg == lfpr_pkg::PH_FRAME,
        cnt_reg >= COUNT_BITS'(2), "byte count below start pair in frame")

endmodule
